[rtl/okpe_pkg.sv]
// Package with the shared types, codes and constants of the ordered key part encoder.
`default_nettype none
package okpe_pkg;

   typedef enum logic [2:0] {
      KIND_NUMBER = 3'd0,
      KIND_DATE   = 3'd1,
      KIND_STRING = 3'd2,
      KIND_ID     = 3'd3,
      KIND_BOUND  = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_NAN       = 2'd1,
      ERR_ZERO_BYTE = 2'd2,
      ERR_ORDER     = 2'd3
   } err_type;

   localparam logic [7:0] TAG_NUMBER = 8'h00;
   localparam logic [7:0] TAG_STRING = 8'h01;
   localparam logic [7:0] TAG_ID     = 8'h02;
   localparam logic [7:0] TAG_DATE   = 8'h03;
   localparam logic [7:0] TAG_BOUND  = 8'hff;
   localparam logic [7:0] STR_TERM   = 8'h00;
   localparam logic [7:0] SIGN_BYTE  = 8'h80;

   localparam logic [63:0] SIGN_MASK = {SIGN_BYTE, 56'h0};

   localparam int WORD_BYTES  = 8;
   localparam int COUNT_W     = $clog2(WORD_BYTES + 1);
   localparam int ID_LOW_BYTES = 4;

   localparam int JOB_FIFO_DEPTH = 2;
   localparam int JOB_PTR_W      = $clog2(JOB_FIFO_DEPTH);
   localparam int JOB_CNT_W      = $clog2(JOB_FIFO_DEPTH + 1);

   typedef struct packed {
      logic       en;
      logic [7:0] data;
      logic       valid;
      err_type    err;
   } slot_type;

   typedef struct packed {
      slot_type             head;
      logic [COUNT_W-1:0]   body_count;
      logic [63:0]          body_word;
      slot_type             tail;
   } job_type;

   localparam slot_type SLOT_NONE = '{en: 1'b0, data: 8'h00, valid: 1'b0, err: ERR_NONE};

   function automatic slot_type byte_slot(input logic [7:0] value);
      slot_type s;
      s = '{en: 1'b1, data: value, valid: 1'b1, err: ERR_NONE};
      return s;
   endfunction

   function automatic slot_type status_slot(input err_type code);
      slot_type s;
      s = '{en: 1'b1, data: 8'h00, valid: 1'b0, err: code};
      return s;
   endfunction

endpackage
`default_nettype wire

[rtl/okpe_chan_if.sv]
// Valid/ready channel interfaces for the request and response sides.
`default_nettype none
interface okpe_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [63:0] payload;
   logic [7:0]  text_byte;
   logic        byte_present;
   logic        part_first;
   logic        part_last;

   modport source (output valid, req_type, payload, text_byte, byte_present, part_first,
                   part_last, input ready);
   modport sink (input valid, req_type, payload, text_byte, byte_present, part_first,
                 part_last, output ready);
endinterface

interface okpe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       run_last;
   logic [1:0] error_code;

   modport source (output valid, out_byte, byte_valid, run_last, error_code, input ready);
   modport sink (input valid, out_byte, byte_valid, run_last, error_code, output ready);
endinterface
`default_nettype wire

[rtl/okpe_front.sv]
// Front end: accepts request beats, tracks part framing and builds output jobs.
`default_nettype none
module okpe_front (
   input  wire logic            clock,
   input  wire logic            reset,
   okpe_req_if.sink             req,
   input  wire logic            fifo_full,
   output logic                 job_push,
   output okpe_pkg::job_type    job
);

   logic string_open_ff, string_open_in;
   logic string_failed_ff, string_failed_in;
   logic id_pending_ff, id_pending_in;

   logic        accept;
   logic        busy;
   logic        is_nan;
   logic        failed_now;
   logic [63:0] num_bits;
   logic [63:0] num_enc;

   assign req.ready = !fifo_full;
   assign accept    = req.valid && !fifo_full;
   assign busy      = string_open_ff || id_pending_ff;
   assign is_nan    = (req.payload[62:52] == 11'h7ff) && (req.payload[51:0] != 52'h0);
   assign num_bits  = (req.payload == okpe_pkg::SIGN_MASK) ? 64'h0 : req.payload;
   assign num_enc   = num_bits[63] ? ~num_bits : (num_bits ^ okpe_pkg::SIGN_MASK);

   always_comb begin
      job.head         = okpe_pkg::SLOT_NONE;
      job.body_count   = '0;
      job.body_word    = '0;
      job.tail         = okpe_pkg::SLOT_NONE;
      string_open_in   = string_open_ff;
      string_failed_in = string_failed_ff;
      id_pending_in    = id_pending_ff;
      failed_now       = string_failed_ff;
      unique case (okpe_pkg::kind_type'(req.req_type))
         okpe_pkg::KIND_NUMBER: begin
            if (busy) begin
               job.head = okpe_pkg::status_slot(okpe_pkg::ERR_ORDER);
               string_open_in = 1'b0; string_failed_in = 1'b0; id_pending_in = 1'b0;
            end else if (is_nan) begin
               job.head = okpe_pkg::status_slot(okpe_pkg::ERR_NAN);
            end else begin
               job.head       = okpe_pkg::byte_slot(okpe_pkg::TAG_NUMBER);
               job.body_count = okpe_pkg::COUNT_W'(okpe_pkg::WORD_BYTES);
               job.body_word  = num_enc;
            end
         end
         okpe_pkg::KIND_DATE: begin
            if (busy) begin
               job.head = okpe_pkg::status_slot(okpe_pkg::ERR_ORDER);
               string_open_in = 1'b0; string_failed_in = 1'b0; id_pending_in = 1'b0;
            end else begin
               job.head       = okpe_pkg::byte_slot(okpe_pkg::TAG_DATE);
               job.body_count = okpe_pkg::COUNT_W'(okpe_pkg::WORD_BYTES);
               job.body_word  = req.payload ^ okpe_pkg::SIGN_MASK;
            end
         end
         okpe_pkg::KIND_STRING: begin
            if ((req.part_first && busy) || (!req.part_first && !string_open_ff)) begin
               job.head = okpe_pkg::status_slot(okpe_pkg::ERR_ORDER);
               string_open_in = 1'b0; string_failed_in = 1'b0; id_pending_in = 1'b0;
            end else begin
               if (req.part_first) begin
                  string_open_in = 1'b1;
                  failed_now     = 1'b0;
                  job.head       = okpe_pkg::byte_slot(okpe_pkg::TAG_STRING);
               end
               if (req.byte_present && !failed_now) begin
                  if (req.text_byte == 8'h00) begin
                     failed_now = 1'b1;
                     job.tail   = okpe_pkg::status_slot(okpe_pkg::ERR_ZERO_BYTE);
                  end else begin
                     job.body_count = okpe_pkg::COUNT_W'(1);
                     job.body_word  = {req.text_byte, 56'h0};
                  end
               end
               string_failed_in = failed_now;
               if (req.part_last) begin
                  if (!failed_now) begin
                     job.tail = okpe_pkg::byte_slot(okpe_pkg::STR_TERM);
                  end
                  string_open_in   = 1'b0;
                  string_failed_in = 1'b0;
               end
            end
         end
         okpe_pkg::KIND_ID: begin
            if (!id_pending_ff) begin
               if (string_open_ff || !req.part_first || req.part_last) begin
                  job.head = okpe_pkg::status_slot(okpe_pkg::ERR_ORDER);
                  string_open_in = 1'b0; string_failed_in = 1'b0; id_pending_in = 1'b0;
               end else begin
                  job.head       = okpe_pkg::byte_slot(okpe_pkg::TAG_ID);
                  job.body_count = okpe_pkg::COUNT_W'(okpe_pkg::WORD_BYTES);
                  job.body_word  = req.payload;
                  id_pending_in  = 1'b1;
               end
            end else begin
               if (req.part_first || !req.part_last) begin
                  job.head = okpe_pkg::status_slot(okpe_pkg::ERR_ORDER);
                  string_open_in = 1'b0; string_failed_in = 1'b0; id_pending_in = 1'b0;
               end else begin
                  job.body_count = okpe_pkg::COUNT_W'(okpe_pkg::ID_LOW_BYTES);
                  job.body_word  = {req.payload[31:0], 32'h0};
                  id_pending_in  = 1'b0;
               end
            end
         end
         okpe_pkg::KIND_BOUND: begin
            if (busy) begin
               job.head = okpe_pkg::status_slot(okpe_pkg::ERR_ORDER);
               string_open_in = 1'b0; string_failed_in = 1'b0; id_pending_in = 1'b0;
            end else begin
               job.head = okpe_pkg::byte_slot(okpe_pkg::TAG_BOUND);
            end
         end
         default: begin
            job.head = okpe_pkg::SLOT_NONE;
         end
      endcase
   end

   assign job_push = accept && (job.head.en || (job.body_count != '0) || job.tail.en);

   always_ff @(posedge clock) begin
      if (reset) begin
         string_open_ff   <= 1'b0;
         string_failed_ff <= 1'b0;
         id_pending_ff    <= 1'b0;
      end else if (accept) begin
         string_open_ff   <= string_open_in;
         string_failed_ff <= string_failed_in;
         id_pending_ff    <= id_pending_in;
      end
   end

endmodule
`default_nettype wire

[rtl/okpe_job_fifo.sv]
// Short job queue between the front end and the byte serializer.
`default_nettype none
module okpe_job_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire okpe_pkg::job_type   push_job,
   input  wire logic                pop,
   output okpe_pkg::job_type        head_job,
   output logic                     full,
   output logic                     empty
);

   okpe_pkg::job_type mem_ff [okpe_pkg::JOB_FIFO_DEPTH];

   logic [okpe_pkg::JOB_PTR_W-1:0] wr_ptr_ff;
   logic [okpe_pkg::JOB_PTR_W-1:0] rd_ptr_ff;
   logic [okpe_pkg::JOB_CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == okpe_pkg::JOB_CNT_W'(okpe_pkg::JOB_FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + okpe_pkg::JOB_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - okpe_pkg::JOB_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + okpe_pkg::JOB_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + okpe_pkg::JOB_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

[rtl/okpe_back.sv]
// Back end: serializes one job into response beats, one byte or status per beat.
`default_nettype none
module okpe_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire okpe_pkg::job_type   head_job,
   input  wire logic                fifo_empty,
   output logic                     pop,
   okpe_rsp_if.source               rsp
);

   logic                              active_ff, active_in;
   okpe_pkg::slot_type                head_ff, head_in;
   okpe_pkg::slot_type                tail_ff, tail_in;
   logic [okpe_pkg::COUNT_W-1:0]      left_ff, left_in;
   logic [63:0]                       word_ff, word_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_byte_ff;
   logic                rsp_bvalid_ff;
   logic                rsp_last_ff;
   okpe_pkg::err_type   rsp_err_ff;

   okpe_pkg::slot_type  cur;
   logic                out_free;
   logic                emit;
   logic                done_after;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign emit     = active_ff && out_free;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      left_in   = left_ff;
      word_in   = word_ff;
      active_in = active_ff;
      pop       = 1'b0;
      if (head_ff.en) begin
         cur        = head_ff;
         head_in.en = 1'b0;
      end else if (left_ff != '0) begin
         cur     = okpe_pkg::byte_slot(word_ff[63:56]);
         word_in = {word_ff[55:0], 8'h00};
         left_in = left_ff - okpe_pkg::COUNT_W'(1);
      end else begin
         cur        = tail_ff;
         tail_in.en = 1'b0;
      end
      done_after = !head_in.en && (left_in == '0) && !tail_in.en;
      if (emit && done_after) begin
         active_in = 1'b0;
      end
      if ((!active_ff || (emit && done_after)) && !fifo_empty) begin
         pop       = 1'b1;
         active_in = 1'b1;
         head_in   = head_job.head;
         tail_in   = head_job.tail;
         left_in   = head_job.body_count;
         word_in   = head_job.body_word;
      end
      rsp_valid_in = out_free ? active_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit || pop) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         left_ff <= left_in;
         word_ff <= word_in;
      end
      if (emit) begin
         rsp_byte_ff   <= cur.data;
         rsp_bvalid_ff <= cur.valid;
         rsp_last_ff   <= done_after;
         rsp_err_ff    <= cur.err;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_byte   = rsp_byte_ff;
   assign rsp.byte_valid = rsp_bvalid_ff;
   assign rsp.run_last   = rsp_last_ff;
   assign rsp.error_code = rsp_err_ff;

endmodule
`default_nettype wire

[rtl/ordered_key_part_encoder_core.sv]
// Top level of the ordered key part encoder: front end, job queue and serializer.
// Path: an accepted request goes to the job queue, then to the serializer's job registers,
// then to the registered response outputs. Throughput: one response beat per cycle while the
// response side is ready, set by the byte-wide serializer; an upper bound or a status is a
// single beat, and numbers, dates, id chunks and string items are serialized byte by byte.
// Reset is synchronous and active high; it closes any open string or id and empties the queue.
`default_nettype none
module ordered_key_part_encoder_core (
   input  wire logic     clock,
   input  wire logic     reset,
   okpe_req_if.sink      req_ch,
   okpe_rsp_if.source    rsp_ch
);

   okpe_pkg::job_type push_job;
   okpe_pkg::job_type head_job;
   logic              job_push;
   logic              job_pop;
   logic              fifo_full;
   logic              fifo_empty;

   okpe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .fifo_full (fifo_full),
      .job_push  (job_push),
      .job       (push_job)
   );

   okpe_job_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (job_pop),
      .head_job (head_job),
      .full     (fifo_full),
      .empty    (fifo_empty)
   );

   okpe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .fifo_empty (fifo_empty),
      .pop        (job_pop),
      .rsp        (rsp_ch)
   );

endmodule
`default_nettype wire
